### rtl/core/msut_pkg.sv
`default_nettype none

package msut_pkg;

  localparam int unsigned NumSourcesDef = 8;
  localparam int unsigned TimeBitsDef   = 32;

  localparam int unsigned SourceW  = 3;
  localparam int unsigned InTimeW  = 32;
  localparam int unsigned OutTimeW = 32;
  localparam int unsigned MaskW    = 8;
  localparam int unsigned CountW   = 4;
  localparam int unsigned CfgGapW  = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [0:0] {
    CmdReport = 1'b0,
    CmdArm    = 1'b1
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRequiredMask = 2'd0,
    CfgMinUpdated   = 2'd1,
    CfgMinGap       = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    cmd_e                 cmd;
    logic [SourceW-1:0]   source;
    logic [InTimeW-1:0]   report_time;
  } item_t;

  typedef struct packed {
    logic                 fired;
    logic [OutTimeW-1:0]  trigger_time;
    logic [CountW-1:0]    updated_count;
    logic [MaskW-1:0]     updated_mask;
    logic                 required_met;
  } result_t;

  typedef struct packed {
    logic [MaskW-1:0]     required_mask;
    logic [CountW-1:0]    min_updated;
    logic [CfgGapW-1:0]   min_gap;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/core/msut_in_stage.sv
`default_nettype none

module msut_in_stage
  import msut_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  input  wire item_t item_i,
  input  wire logic  adv_i,
  output logic       valid_o,
  output item_t      item_o
);

  logic  valid_q, valid_d;
  logic  accept;
  item_t item_q;

  assign in_stall_o = valid_q && !adv_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (accept) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

### rtl/core/msut_core.sv
`default_nettype none

module msut_core
  import msut_pkg::*;
#(
  parameter int unsigned NUM_SOURCES = NumSourcesDef,
  parameter int unsigned TIME_BITS   = TimeBitsDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  step_i,
  input  wire item_t item_i,
  input  wire cfg_t  cfg_i,
  output result_t    result_o
);

  localparam int unsigned CntW = $clog2(NUM_SOURCES + 1);
  localparam int unsigned GapW = (TIME_BITS > CfgGapW) ? TIME_BITS : CfgGapW;

  // A source's baseline equals its stored time until a report raises it, so
  // the updated bit alone records whether the stored time passed the baseline.
  logic [TIME_BITS-1:0]   src_time_q [NUM_SOURCES];
  logic [NUM_SOURCES-1:0] upd_q, upd_d;
  logic [TIME_BITS-1:0]   newest_q, newest_d;
  logic [TIME_BITS-1:0]   last_q, last_d;
  logic                   armed_q, armed_d;

  logic                   src_ok;
  logic [TIME_BITS-1:0]   t;
  logic [TIME_BITS-1:0]   cur;
  logic                   raise;
  logic [NUM_SOURCES-1:0] upd_eval;
  logic [TIME_BITS-1:0]   newest_eval;
  logic                   armed_eval;
  logic [NUM_SOURCES-1:0] req;
  logic                   req_met;
  logic [CntW-1:0]        count;
  logic [TIME_BITS-1:0]   diff;
  logic                   gap_ok;
  logic                   fire;

  assign src_ok = 32'(item_i.source) < NUM_SOURCES;
  assign t      = TIME_BITS'(item_i.report_time);

  always_comb begin
    cur = '0;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      if (32'(item_i.source) == i) begin
        cur = src_time_q[i];
      end
    end
  end

  assign raise = (item_i.cmd == CmdReport) && src_ok && (t > cur);

  always_comb begin
    unique case (item_i.cmd)
      CmdArm: begin
        upd_eval    = '0;
        newest_eval = newest_q;
        armed_eval  = 1'b1;
      end
      CmdReport: begin
        upd_eval    = upd_q;
        newest_eval = newest_q;
        armed_eval  = armed_q;
        if (raise) begin
          upd_eval = upd_q | (NUM_SOURCES'(1) << item_i.source);
          if (t > newest_q) begin
            newest_eval = t;
          end
        end
      end
      default: begin
        upd_eval    = upd_q;
        newest_eval = newest_q;
        armed_eval  = armed_q;
      end
    endcase
  end

  assign req     = NUM_SOURCES'(cfg_i.required_mask);
  assign req_met = (upd_eval & req) == req;

  always_comb begin
    count = '0;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      count = count + CntW'(upd_eval[i]);
    end
  end

  assign diff   = newest_eval - last_q;
  assign gap_ok = (newest_eval >= last_q) && (GapW'(diff) >= GapW'(cfg_i.min_gap));

  assign fire = armed_eval && req_met && (32'(count) >= 32'(cfg_i.min_updated)) &&
                (newest_eval != '0) && gap_ok;

  assign upd_d    = fire ? '0 : upd_eval;
  assign armed_d  = fire ? 1'b0 : armed_eval;
  assign last_d   = fire ? newest_eval : last_q;
  assign newest_d = newest_eval;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upd_q    <= '0;
      newest_q <= '0;
      last_q   <= '0;
      armed_q  <= 1'b1;
      for (int i = 0; i < NUM_SOURCES; i++) begin
        src_time_q[i] <= '0;
      end
    end else if (step_i) begin
      upd_q    <= upd_d;
      newest_q <= newest_d;
      last_q   <= last_d;
      armed_q  <= armed_d;
      for (int i = 0; i < NUM_SOURCES; i++) begin
        if (raise && (32'(item_i.source) == i)) begin
          src_time_q[i] <= t;
        end
      end
    end
  end

  assign result_o.fired         = fire;
  assign result_o.trigger_time  = OutTimeW'(newest_eval);
  assign result_o.updated_count = CountW'(count);
  assign result_o.updated_mask  = MaskW'(upd_eval);
  assign result_o.required_met  = req_met;

endmodule

`default_nettype wire

### rtl/core/msut_out_stage.sv
`default_nettype none

module msut_out_stage
  import msut_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t result_i,
  output logic         free_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output result_t      result_o
);

  logic    valid_q, valid_d;
  result_t result_q;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

### rtl/core/multi_source_update_trigger.sv
`default_nettype none

// Multi-source update trigger. Each input transfer is a source time report or
// an arm command and gives exactly one result transfer. One item is taken per
// cycle while the result side does not stall; an item passes through the input
// register and then the result register. The whole update and fire decision
// for an item (one source entry, the running maximum, the popcount and the gap
// compare) sits in the single path between the two registers. A stall on the
// result side holds both registers and shows up on in_stall_o in the same
// cycle. Configuration is always ready and should be written only while no
// item is in flight.

module multi_source_update_trigger
  import msut_pkg::*;
#(
  parameter int unsigned NUM_SOURCES = NumSourcesDef,
  parameter int unsigned TIME_BITS   = TimeBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                cmd_i,
  input  wire logic [SourceW-1:0]  source_i,
  input  wire logic [InTimeW-1:0]  report_time_i,

  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     fired_o,
  output logic [OutTimeW-1:0]      trigger_time_o,
  output logic [CountW-1:0]        updated_count_o,
  output logic [MaskW-1:0]         updated_mask_o,
  output logic                     required_met_o,

  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  item_t   in_item;
  item_t   s1_item;
  logic    s1_valid;
  logic    out_free;
  logic    adv;
  result_t core_result;
  result_t out_result;
  cfg_t    cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgRequiredMask: cfg_d.required_mask = cfg_data_i[MaskW-1:0];
        CfgMinUpdated:   cfg_d.min_updated   = cfg_data_i[CountW-1:0];
        CfgMinGap:       cfg_d.min_gap       = cfg_data_i[CfgGapW-1:0];
        default:         cfg_d               = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_item.cmd         = cmd_e'(cmd_i);
  assign in_item.source      = source_i;
  assign in_item.report_time = report_time_i;

  assign adv = s1_valid && out_free;

  msut_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .adv_i      (adv),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  msut_core #(
    .NUM_SOURCES (NUM_SOURCES),
    .TIME_BITS   (TIME_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv),
    .item_i   (s1_item),
    .cfg_i    (cfg_q),
    .result_o (core_result)
  );

  msut_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv),
    .result_i    (core_result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_result)
  );

  assign fired_o         = out_result.fired;
  assign trigger_time_o  = out_result.trigger_time;
  assign updated_count_o = out_result.updated_count;
  assign updated_mask_o  = out_result.updated_mask;
  assign required_met_o  = out_result.required_met;

endmodule

`default_nettype wire

### rtl/core/msut_checker.sv
`default_nettype none

module msut_checker
  import msut_pkg::*;
#(
  parameter int unsigned TIME_BITS = TimeBitsDef
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire logic                fired_o,
  input wire logic [OutTimeW-1:0] trigger_time_o,
  input wire logic [CountW-1:0]   updated_count_o,
  input wire logic [MaskW-1:0]    updated_mask_o,
  input wire logic                required_met_o
);

  logic                out_xfer;
  logic                seen_q;
  logic [OutTimeW-1:0] last_tt_q;

  assign out_xfer = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= 1'b0;
      last_tt_q <= '0;
    end else if (out_xfer) begin
      seen_q    <= 1'b1;
      last_tt_q <= trigger_time_o;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(fired_o) &&
      $stable(trigger_time_o) && $stable(updated_count_o) &&
      $stable(updated_mask_o) && $stable(required_met_o))
    else $error("result changed while stalled");

  // input side only backs up behind a stalled, full result register
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // newest time never falls from one result transfer to the next
  a_time_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && seen_q |-> (TIME_BITS > OutTimeW) || (trigger_time_o >= last_tt_q))
    else $error("trigger time went backwards");

  a_fire_cond: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && fired_o |-> required_met_o && $past(in_valid_i || !in_valid_i))
    else $error("fired without required sources met");

endmodule

bind multi_source_update_trigger msut_checker #(
  .TIME_BITS (TIME_BITS)
) u_msut_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .fired_o         (fired_o),
  .trigger_time_o  (trigger_time_o),
  .updated_count_o (updated_count_o),
  .updated_mask_o  (updated_mask_o),
  .required_met_o  (required_met_o)
);

`default_nettype wire
